// ===== src/vcri_pkg.sv =====
// Shared constants and types for the video CPU register interface.
// No dependencies.
package vcri_pkg;

    localparam int OAM_BYTES        = 256;
    localparam int NAME_TABLE_BYTES = 1024;
    localparam int PATTERN_BYTES    = 8192;
    localparam int PALETTE_BYTES    = 32;

    localparam int OAM_AW = $clog2(OAM_BYTES);
    localparam int NT_OFS_W = $clog2(NAME_TABLE_BYTES);
    localparam int NT_AW  = NT_OFS_W + 1;
    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam int PAL_AW = $clog2(PALETTE_BYTES);

    localparam logic [2:0] FUNC_READ   = 3'd0;
    localparam logic [2:0] FUNC_WRITE  = 3'd1;
    localparam logic [2:0] FUNC_PEEK   = 3'd2;
    localparam logic [2:0] FUNC_VBLANK = 3'd3;
    localparam logic [2:0] FUNC_FRAME  = 3'd4;

    localparam logic [2:0] REG_CONTROL  = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    localparam logic [1:0] MIRROR_VERT  = 2'd0;
    localparam logic [1:0] MIRROR_HORIZ = 2'd1;

    localparam logic [13:0] NT_BASE  = 14'h2000;
    localparam logic [13:0] PAL_BASE = 14'h3F00;

    localparam logic [7:0] PAL_MASK_GRAY  = 8'h30;
    localparam logic [7:0] PAL_MASK_COLOR = 8'h3F;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

endpackage

// ===== src/vcri_ctrl.sv =====
// Sequencer for the register interface: capture beat, then commit beat.
// Depends on vcri_pkg.
module vcri_ctrl
    import vcri_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output t_dp_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.commit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state == S_EXEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_commit_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.commit)
        else $error("capture not followed by commit");
    a_commit_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> $past(o_cmd.capture))
        else $error("commit without capture");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.capture && o_cmd.commit) && !(busy && o_cmd.capture))
        else $error("capture overlaps commit");

endmodule

// ===== src/vcri_datapath.sv =====
// Register file, video memories and access logic of the register interface.
// Depends on vcri_pkg; sequenced by vcri_ctrl.
module vcri_datapath
    import vcri_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic [2:0]  i_func,
    input  logic [2:0]  i_reg_addr,
    input  logic [7:0]  i_write_data,
    output logic        o_done,
    output logic [7:0]  o_read_data,
    output logic [15:0] o_vram_addr,
    output logic [2:0]  o_fine_x_scroll,
    output logic        o_vblank_flag
);

    logic [7:0] oam_mem [OAM_BYTES];
    logic [7:0] nt_mem  [2 * NAME_TABLE_BYTES];
    logic [7:0] pal_mem [PALETTE_BYTES];
    logic [7:0] pat_mem [PATTERN_BYTES];

    logic [1:0]  r_mirror;
    logic [7:0]  r_control, n_control;
    logic [7:0]  r_mask, n_mask;
    logic [2:0]  r_flags, n_flags;
    logic [14:0] r_temp, n_temp;
    logic [15:0] r_cur, n_cur;
    logic        r_toggle, n_toggle;
    logic [2:0]  r_fine_x, n_fine_x;
    logic [7:0]  r_buf, n_buf;
    logic [7:0]  r_oam_addr, n_oam_addr;

    logic [2:0]  r_func;
    logic [2:0]  r_reg;
    logic [7:0]  r_wdata;
    logic [7:0]  r_oam_rd, r_nt_rd, r_pal_rd, r_pat_rd;
    logic        r_done;
    logic [7:0]  r_rdata, n_rdata;

    logic [13:0]       va;
    logic              nt_ok;
    logic [NT_AW-1:0]  nt_idx;
    logic [PAL_AW-1:0] pal_idx;
    logic [PAT_AW-1:0] pat_idx;
    logic [OAM_AW-1:0] oam_idx;
    logic              in_pat, in_pal;
    logic [7:0]        video_rd;
    logic [15:0]       cur_step;
    logic              we_pat, we_nt, we_pal, we_oam;

    assign va      = r_cur[13:0];
    assign in_pat  = (va < NT_BASE);
    assign in_pal  = (va >= PAL_BASE);
    assign pat_idx = va[PAT_AW-1:0];
    assign oam_idx = r_oam_addr[OAM_AW-1:0];
    assign nt_ok   = (r_mirror == MIRROR_VERT) || (r_mirror == MIRROR_HORIZ);
    assign nt_idx  = {(r_mirror == MIRROR_VERT) ? va[10] : va[11], va[NT_OFS_W-1:0]};
    assign pal_idx = (va[4] && (va[1:0] == 2'b00)) ? {1'b0, va[3:0]} : va[PAL_AW-1:0];
    assign cur_step = r_cur + (r_control[2] ? 16'd32 : 16'd1);

    always_comb begin
        if (in_pat) begin
            video_rd = r_pat_rd;
        end else if (!in_pal) begin
            video_rd = nt_ok ? r_nt_rd : 8'h00;
        end else begin
            video_rd = r_pal_rd & (r_mask[0] ? PAL_MASK_GRAY : PAL_MASK_COLOR);
        end
    end

    always_comb begin
        n_control  = r_control;
        n_mask     = r_mask;
        n_flags    = r_flags;
        n_temp     = r_temp;
        n_cur      = r_cur;
        n_toggle   = r_toggle;
        n_fine_x   = r_fine_x;
        n_buf      = r_buf;
        n_oam_addr = r_oam_addr;
        n_rdata    = 8'h00;
        we_pat     = 1'b0;
        we_nt      = 1'b0;
        we_pal     = 1'b0;
        we_oam     = 1'b0;
        case (r_func)
            FUNC_READ: begin
                case (r_reg)
                    REG_STATUS: begin
                        n_rdata    = {r_flags, r_buf[4:0]};
                        n_flags[2] = 1'b0;
                        n_toggle   = 1'b0;
                    end
                    REG_OAM_DATA: n_rdata = r_oam_rd;
                    REG_DATA: begin
                        n_rdata = in_pal ? video_rd : r_buf;
                        n_buf   = video_rd;
                        n_cur   = cur_step;
                    end
                    default: n_rdata = 8'h00;
                endcase
            end
            FUNC_WRITE: begin
                case (r_reg)
                    REG_CONTROL: begin
                        n_control     = r_wdata;
                        n_temp[11:10] = r_wdata[1:0];
                    end
                    REG_MASK:     n_mask = r_wdata;
                    REG_OAM_ADDR: n_oam_addr = r_wdata;
                    REG_OAM_DATA: we_oam = 1'b1;
                    REG_SCROLL: begin
                        if (!r_toggle) begin
                            n_fine_x    = r_wdata[2:0];
                            n_temp[4:0] = r_wdata[7:3];
                            n_toggle    = 1'b1;
                        end else begin
                            n_temp[14:12] = r_wdata[2:0];
                            n_temp[9:5]   = r_wdata[7:3];
                            n_toggle      = 1'b0;
                        end
                    end
                    REG_ADDR: begin
                        if (!r_toggle) begin
                            n_temp   = {1'b0, r_wdata[5:0], r_temp[7:0]};
                            n_toggle = 1'b1;
                        end else begin
                            n_temp   = {r_temp[14:8], r_wdata};
                            n_cur    = {1'b0, r_temp[14:8], r_wdata};
                            n_toggle = 1'b0;
                        end
                    end
                    REG_DATA: begin
                        we_pat = in_pat;
                        we_nt  = !in_pat && !in_pal && nt_ok;
                        we_pal = in_pal;
                        n_cur  = cur_step;
                    end
                    default: n_rdata = 8'h00;
                endcase
            end
            FUNC_PEEK: begin
                case (r_reg)
                    REG_CONTROL: n_rdata = r_control;
                    REG_MASK:    n_rdata = r_mask;
                    REG_STATUS:  n_rdata = {r_flags, 5'b0};
                    default:     n_rdata = 8'h00;
                endcase
            end
            FUNC_VBLANK: n_flags[2] = 1'b1;
            FUNC_FRAME:  n_flags = 3'b000;
            default:     n_rdata = 8'h00;
        endcase
    end

    // synchronous memory reads on the capture beat, writes on the commit beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_oam_rd <= oam_mem[oam_idx];
            r_nt_rd  <= nt_mem[nt_idx];
            r_pal_rd <= pal_mem[pal_idx];
            r_pat_rd <= pat_mem[pat_idx];
        end
        if (i_cmd.commit) begin
            if (we_oam) oam_mem[oam_idx] <= r_wdata;
            if (we_nt)  nt_mem[nt_idx]   <= r_wdata;
            if (we_pal) pal_mem[pal_idx] <= r_wdata;
            if (we_pat) pat_mem[pat_idx] <= r_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_func;
            r_reg   <= i_reg_addr;
            r_wdata <= i_write_data;
        end
        if (i_cmd.commit) begin
            r_rdata <= n_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror   <= MIRROR_VERT;
            r_control  <= '0;
            r_mask     <= '0;
            r_flags    <= '0;
            r_temp     <= '0;
            r_cur      <= '0;
            r_toggle   <= 1'b0;
            r_fine_x   <= '0;
            r_buf      <= '0;
            r_oam_addr <= '0;
            r_done     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mirror <= i_cfg_wdata;
            end
            r_done <= i_cmd.commit;
            if (i_cmd.commit) begin
                r_control  <= n_control;
                r_mask     <= n_mask;
                r_flags    <= n_flags;
                r_temp     <= n_temp;
                r_cur      <= n_cur;
                r_toggle   <= n_toggle;
                r_fine_x   <= n_fine_x;
                r_buf      <= n_buf;
                r_oam_addr <= n_oam_addr;
            end
        end
    end

    assign o_done          = r_done;
    assign o_read_data     = r_rdata;
    assign o_vram_addr     = r_cur;
    assign o_fine_x_scroll = r_fine_x;
    assign o_vblank_flag   = r_flags[2];

endmodule

// ===== src/video_cpu_register_interface_core.sv =====
// Top level of the video CPU register interface.
// Depends on vcri_pkg, vcri_ctrl and vcri_datapath.
//
// Each access is issued with start while busy is low and runs as a capture
// beat for the synchronous read of the video memories, then a commit beat to
// update the registers and memories. busy is high during the commit beat; one
// result beat follows with o_done high for exactly one cycle and must be taken
// then, as the block cannot be held off. A new access may start in the cycle
// the result beat is shown. mirror_mode must be written through i_cfg_we and
// i_cfg_wdata only while no access is in flight; the block does not enforce it.
module video_cpu_register_interface_core
    import vcri_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic [2:0]  i_func,
    input  logic [2:0]  i_reg_addr,
    input  logic [7:0]  i_write_data,
    output logic        o_done,
    output logic [7:0]  o_read_data,
    output logic [15:0] o_vram_addr,
    output logic [2:0]  o_fine_x_scroll,
    output logic        o_vblank_flag
);

    t_dp_cmd cmd;

    vcri_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    vcri_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_func          (i_func),
        .i_reg_addr      (i_reg_addr),
        .i_write_data    (i_write_data),
        .o_done          (o_done),
        .o_read_data     (o_read_data),
        .o_vram_addr     (o_vram_addr),
        .o_fine_x_scroll (o_fine_x_scroll),
        .o_vblank_flag   (o_vblank_flag)
    );

endmodule
